[src/cke_pkg.sv]
// Shared constants and the CRC-32 byte step for the keyed entry lookup.
`default_nettype none
package cke_pkg;

   localparam int INDEX_BITS = 16;
   localparam int COUNT_BITS = (INDEX_BITS < 16) ? INDEX_BITS : 16;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [15:0] EQUAL_CHAR = 16'h003D;

   // request function codes
   localparam logic [1:0] FUNC_NAME   = 2'd0;
   localparam logic [1:0] FUNC_ENTRY  = 2'd1;
   localparam logic [1:0] FUNC_END    = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef logic [31:0] crc_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // Reflected CRC-32 over one byte, bit at a time.
   function automatic crc_type crc_byte(input crc_type c, input logic [7:0] b);
      crc_type r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[src/cke_crc_step.sv]
// CRC-32 update over one 16-bit character, low byte first.
`default_nettype none
module cke_crc_step (
   input  wire cke_pkg::crc_type crc_in,
   input  wire logic [15:0]      char_code,
   output cke_pkg::crc_type      crc_out
);
   import cke_pkg::*;

   crc_type low_crc;

   assign low_crc = crc_byte(crc_in, char_code[7:0]);
   assign crc_out = crc_byte(low_crc, char_code[15:8]);

endmodule
`default_nettype wire

[src/crc32_keyed_entry_lookup_top.sv]
// Top level of the CRC-32 keyed entry lookup.
//
// Usage: stream the target name characters (func 0, last on the final one),
// or write a nonzero hash to the csr channel beforehand and skip the name.
// Then stream entries "name=value" (func 1, last on each entry's final
// character) and close the list with one func 2 beat. Only the end-of-list
// beat produces a response beat; all other beats update internal state only.
// Every request beat is handled in the cycle it is accepted: one character
// is two CRC byte steps through a single combinational update, so the block
// takes one request per cycle. The response is held in an output register
// and appears the cycle after the end-of-list beat is accepted. While that
// response waits on a stalled rsp_ready, req_ready drops and requests hold;
// when the response is taken in the same cycle a new request is accepted.
// The csr channel is always ready and should be written only while idle.
// Synchronous reset clears the lookup state, the preset hash and the
// response valid flag. After each end-of-list beat the lookup state returns
// to its reset value for the next lookup; the preset hash is kept.
`default_nettype none
module crc32_keyed_entry_lookup_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [15:0] req_char_code,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_status,
   output logic             rsp_found,
   output logic [31:0]      rsp_target_crc,
   output logic [15:0]      rsp_entry_index,
   output logic [15:0]      rsp_value_offset,
   output logic [31:0]      rsp_value_crc,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_wdata
);
   import cke_pkg::*;

   localparam logic [2:0] P_NAME  = 3'd0;
   localparam logic [2:0] P_LIST  = 3'd1;
   localparam logic [2:0] P_ENAME = 3'd2;
   localparam logic [2:0] P_SKIP  = 3'd3;
   localparam logic [2:0] P_VALUE = 3'd4;
   localparam logic [2:0] P_DONE  = 3'd5;
   localparam logic [2:0] P_ERROR = 3'd6;

   localparam count_type INDEX_CAP = '1;

   crc_type     preset_ff;
   crc_type     crc_ff, crc_in;
   crc_type     target_ff, target_in;
   count_type   count_ff, count_in;
   logic [15:0] pos_ff, pos_in;
   logic [2:0]  phase_ff, phase_in;
   count_type   match_index_ff, match_index_in;
   logic [15:0] match_offset_ff, match_offset_in;
   crc_type     value_crc_ff, value_crc_in;
   logic        error_ff, error_in;

   logic        rsp_valid_ff;
   logic        rsp_status_ff, rsp_status_in;
   logic        rsp_found_ff, rsp_found_in;
   crc_type     rsp_target_crc_ff, rsp_target_crc_in;
   logic [15:0] rsp_index_ff, rsp_index_in;
   logic [15:0] rsp_offset_ff, rsp_offset_in;
   crc_type     rsp_value_crc_ff, rsp_value_crc_in;
   logic        emit;

   logic        req_fire;
   logic        restart;
   crc_type     crc_src;
   crc_type     crc_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // An entry's first character restarts the CRC from the initial value.
   assign restart = (req_func == FUNC_ENTRY) && ((phase_ff == P_NAME) || (phase_ff == P_LIST));
   assign crc_src = restart ? CRC_INIT : crc_ff;

   cke_crc_step u_crc_step (
      .crc_in    (crc_src),
      .char_code (req_char_code),
      .crc_out   (crc_next)
   );

   always_comb begin
      crc_in            = crc_ff;
      target_in         = target_ff;
      count_in          = count_ff;
      pos_in            = pos_ff;
      phase_in          = phase_ff;
      match_index_in    = match_index_ff;
      match_offset_in   = match_offset_ff;
      value_crc_in      = value_crc_ff;
      error_in          = error_ff;
      emit              = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_found_in      = rsp_found_ff;
      rsp_target_crc_in = rsp_target_crc_ff;
      rsp_index_in      = rsp_index_ff;
      rsp_offset_in     = rsp_offset_ff;
      rsp_value_crc_in  = rsp_value_crc_ff;

      if (req_fire) begin
         case (req_func)
            FUNC_NAME: begin
               if (phase_in == P_NAME) begin
                  crc_in = crc_next;
                  if (req_last) begin
                     target_in = (preset_ff != '0) ? preset_ff : (crc_next ^ CRC_INIT);
                     phase_in  = P_LIST;
                  end
               end
            end
            FUNC_ENTRY: begin
               if (phase_in == P_NAME) begin
                  target_in = (preset_ff != '0) ? preset_ff : (crc_ff ^ CRC_INIT);
                  phase_in  = P_LIST;
               end
               if (phase_in == P_LIST) begin
                  crc_in   = CRC_INIT;
                  pos_in   = '0;
                  phase_in = P_ENAME;
               end
               case (phase_in)
                  P_ENAME: begin
                     if (req_char_code == EQUAL_CHAR) begin
                        if ((crc_in ^ CRC_INIT) == target_in) begin
                           match_index_in  = count_in;
                           match_offset_in = (pos_in != 16'hFFFF) ? pos_in + 16'd1 : 16'hFFFF;
                           crc_in          = CRC_INIT;
                           phase_in        = P_VALUE;
                           if (req_last) begin
                              value_crc_in = '0;
                              phase_in     = P_DONE;
                           end
                        end else if (req_last) begin
                           if (count_in != INDEX_CAP) count_in = count_in + count_type'(1);
                           phase_in = P_LIST;
                        end else begin
                           phase_in = P_SKIP;
                        end
                     end else begin
                        crc_in = crc_next;
                        if (pos_in != 16'hFFFF) pos_in = pos_in + 16'd1;
                        if (req_last) begin
                           error_in = 1'b1;
                           phase_in = P_ERROR;
                        end
                     end
                  end
                  P_SKIP: begin
                     if (req_last) begin
                        if (count_in != INDEX_CAP) count_in = count_in + count_type'(1);
                        phase_in = P_LIST;
                     end
                  end
                  P_VALUE: begin
                     crc_in = crc_next;
                     if (req_last) begin
                        value_crc_in = crc_next ^ CRC_INIT;
                        phase_in     = P_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            FUNC_END: begin
               if (phase_in == P_NAME) begin
                  target_in = (preset_ff != '0) ? preset_ff : (crc_ff ^ CRC_INIT);
                  phase_in  = P_LIST;
               end
               if (phase_in == P_ENAME) begin
                  error_in = 1'b1;
                  phase_in = P_ERROR;
               end
               if (phase_in == P_VALUE) begin
                  value_crc_in = crc_in ^ CRC_INIT;
                  phase_in     = P_DONE;
               end
               emit              = 1'b1;
               rsp_status_in     = error_in;
               rsp_found_in      = (phase_in == P_DONE) && !error_in;
               rsp_target_crc_in = target_in;
               rsp_index_in      = rsp_found_in ? 16'(match_index_in) : 16'd0;
               rsp_offset_in     = rsp_found_in ? match_offset_in : 16'd0;
               rsp_value_crc_in  = rsp_found_in ? value_crc_in : '0;
               // drop the lookup state for the next list
               crc_in          = CRC_INIT;
               target_in       = '0;
               count_in        = '0;
               pos_in          = '0;
               phase_in        = P_NAME;
               match_index_in  = '0;
               match_offset_in = '0;
               value_crc_in    = '0;
               error_in        = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_ff       <= '0;
         crc_ff          <= CRC_INIT;
         target_ff       <= '0;
         count_ff        <= '0;
         pos_ff          <= '0;
         phase_ff        <= P_NAME;
         match_index_ff  <= '0;
         match_offset_ff <= '0;
         value_crc_ff    <= '0;
         error_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) preset_ff <= csr_wdata;
         crc_ff          <= crc_in;
         target_ff       <= target_in;
         count_ff        <= count_in;
         pos_ff          <= pos_in;
         phase_ff        <= phase_in;
         match_index_ff  <= match_index_in;
         match_offset_ff <= match_offset_in;
         value_crc_ff    <= value_crc_in;
         error_ff        <= error_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload holds until the next end-of-list beat
   always_ff @(posedge clock) begin
      rsp_status_ff     <= rsp_status_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_target_crc_ff <= rsp_target_crc_in;
      rsp_index_ff      <= rsp_index_in;
      rsp_offset_ff     <= rsp_offset_in;
      rsp_value_crc_ff  <= rsp_value_crc_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_target_crc   = rsp_target_crc_ff;
   assign rsp_entry_index  = rsp_index_ff;
   assign rsp_value_offset = rsp_offset_ff;
   assign rsp_value_crc    = rsp_value_crc_ff;

   a_found_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_status_ff && rsp_found_ff))
      else $error("response reports both a match and an illegal entry");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |->
         (rsp_index_ff == 16'd0 && rsp_offset_ff == 16'd0 && rsp_value_crc_ff == '0))
      else $error("response without a match carries match data");

   a_end_rearms: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_func == FUNC_END) |=> (phase_ff == P_NAME && rsp_valid_ff))
      else $error("end-of-list beat did not rearm the lookup");

   a_error_flag: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == P_ERROR) |-> error_ff)
      else $error("error phase without error flag");

endmodule
`default_nettype wire
